// ----- rtl/kms_pkg.sv -----
// kms_pkg: sizes, operation codes, entry and cell-control types for keyed_mode_stack.
// No dependencies; used by kms_cell and keyed_mode_stack.
package kms_pkg;

  localparam int DEPTH      = 4;
  localparam int APP_COUNT  = 10;
  localparam int MODE_COUNT = 10;

  localparam int KEY_W  = 3;
  localparam int MODE_W = 4;
  localparam int APP_W  = 4;
  localparam int FILL_W = 3;

  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SLOT_KEY_W = (IDX_W < KEY_W) ? IDX_W : KEY_W;

  typedef enum logic {
    OP_ADD,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic [SLOT_KEY_W-1:0] key;
    logic [MODE_W-1:0]     mode;
    logic [APP_W-1:0]      app;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   data;
  } cell_ctl_t;

endpackage

// ----- rtl/keyed_mode_stack.sv -----
// keyed_mode_stack: keyed (key, mode, app) stack built as a row of kms_cell
// slots with a small sequencer. Depends on kms_pkg and kms_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: op, key, mode, app.
//   op 0 adds or updates the entry for key; op 1 removes the entry for key,
//   the slots above it shifting down one place.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   ok, top_mode, top_app and fill (entries stacked afterwards).
//   The sequencer steps are accept, key search across all cells, cell
//   update and result load; a new input word is taken only after the
//   last step, so one word is handled at a time.
//   The output register lets a new input word be taken while a result
//   still waits; if the receiver stalls, the following result is held in
//   the last step until the output register is free, and in_ready stays low.
//   Reset (rst, synchronous) empties the stack, zeroes every slot and
//   drops any pending result.
module keyed_mode_stack (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [kms_pkg::KEY_W-1:0]  key,
  input  logic [kms_pkg::MODE_W-1:0] mode,
  input  logic [kms_pkg::APP_W-1:0]  app,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ok,
  output logic [kms_pkg::MODE_W-1:0] top_mode,
  output logic [kms_pkg::APP_W-1:0]  top_app,
  output logic [kms_pkg::FILL_W-1:0] fill
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                     state;
  kms_pkg::op_t               op_q;
  logic [kms_pkg::KEY_W-1:0]  key_q;
  logic [kms_pkg::MODE_W-1:0] mode_q;
  logic [kms_pkg::APP_W-1:0]  app_q;
  logic [kms_pkg::CNT_W-1:0]  fill_q;
  logic [kms_pkg::DEPTH-1:0]  match_q;
  logic [kms_pkg::DEPTH-1:0]  above_q;
  logic                       hit_q;

  kms_pkg::entry_t    cell_cur [kms_pkg::DEPTH];
  kms_pkg::cell_ctl_t cell_ctl [kms_pkg::DEPTH];
  logic [kms_pkg::DEPTH-1:0] match_vec;
  logic [kms_pkg::DEPTH-1:0] above_vec;
  logic                      add_ok;
  logic                      has_room;
  logic [kms_pkg::CNT_W-1:0] top_cnt;
  logic [kms_pkg::IDX_W-1:0] top_idx;
  kms_pkg::entry_t           load_data;

  for (genvar i = 0; i < kms_pkg::DEPTH; i++) begin : g_cell
    kms_pkg::entry_t up_entry;
    if (i == kms_pkg::DEPTH - 1) begin : g_top
      assign up_entry = '0;
    end else begin : g_mid
      assign up_entry = cell_cur[i+1];
    end
    kms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[i]),
      .up       (up_entry),
      .occupied (fill_q > kms_pkg::CNT_W'(i)),
      .key      (key_q),
      .cur      (cell_cur[i]),
      .match    (match_vec[i])
    );
  end

  // cells at or above the matching slot
  always_comb begin
    above_vec[0] = match_vec[0];
    for (int i = 1; i < kms_pkg::DEPTH; i++) begin
      above_vec[i] = above_vec[i-1] | match_vec[i];
    end
  end

  assign add_ok = (int'(key_q) < kms_pkg::DEPTH) && (int'(mode_q) < kms_pkg::MODE_COUNT) &&
                  (int'(app_q) < kms_pkg::APP_COUNT);
  assign has_room  = fill_q < kms_pkg::CNT_W'(kms_pkg::DEPTH);
  assign top_cnt   = fill_q - kms_pkg::CNT_W'(1);
  assign top_idx   = top_cnt[kms_pkg::IDX_W-1:0];
  assign load_data = '{key: key_q[kms_pkg::SLOT_KEY_W-1:0], mode: mode_q, app: app_q};

  always_comb begin
    for (int i = 0; i < kms_pkg::DEPTH; i++) begin
      cell_ctl[i].op   = kms_pkg::CELL_HOLD;
      cell_ctl[i].data = load_data;
      if (state == S_APPLY) begin
        if (op_q == kms_pkg::OP_ADD) begin
          if (add_ok && hit_q && match_q[i]) begin
            cell_ctl[i].op = kms_pkg::CELL_LOAD;
          end else if (add_ok && !hit_q && has_room && fill_q == kms_pkg::CNT_W'(i)) begin
            cell_ctl[i].op = kms_pkg::CELL_LOAD;
          end
        end else if (hit_q) begin
          if (top_cnt == kms_pkg::CNT_W'(i)) begin
            cell_ctl[i].op = kms_pkg::CELL_CLEAR;
          end else if (above_q[i] && top_cnt > kms_pkg::CNT_W'(i)) begin
            cell_ctl[i].op = kms_pkg::CELL_SHIFT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill_q    <= '0;
      out_valid <= 1'b0;
      op_q      <= kms_pkg::OP_ADD;
      key_q     <= '0;
      mode_q    <= '0;
      app_q     <= '0;
      match_q   <= '0;
      above_q   <= '0;
      hit_q     <= 1'b0;
      ok        <= 1'b0;
      top_mode  <= '0;
      top_app   <= '0;
      fill      <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= kms_pkg::op_t'(op);
            key_q  <= key;
            mode_q <= mode;
            app_q  <= app;
            state  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          match_q <= match_vec;
          above_q <= above_vec;
          hit_q   <= |match_vec;
          state   <= S_APPLY;
        end
        S_APPLY: begin
          if (op_q == kms_pkg::OP_ADD) begin
            if (add_ok && !hit_q && has_room) begin
              fill_q <= fill_q + kms_pkg::CNT_W'(1);
            end
          end else if (hit_q) begin
            fill_q <= top_cnt;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            fill      <= kms_pkg::FILL_W'(fill_q);
            if (op_q == kms_pkg::OP_ADD) begin
              ok       <= add_ok;
              top_mode <= '0;
              top_app  <= '0;
            end else if (fill_q != '0) begin
              ok       <= 1'b1;
              top_mode <= cell_cur[top_idx].mode;
              top_app  <= cell_cur[top_idx].app;
            end else begin
              ok       <= 1'b0;
              top_mode <= '0;
              top_app  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_q <= kms_pkg::CNT_W'(kms_pkg::DEPTH))
    else $error("stack count above depth");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> $onehot0(match_vec))
    else $error("key stacked more than once");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && op_q == kms_pkg::OP_REMOVE && hit_q) |=> fill_q == $past(top_cnt))
    else $error("remove did not drop one entry");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && op_q == kms_pkg::OP_ADD) |=> fill_q >= $past(fill_q))
    else $error("add reduced the stack");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while an item is in progress");

endmodule

// ----- rtl/kms_cell.sv -----
// kms_cell: one stack slot; holds an entry, loads, shifts down from its upper
// neighbor or clears, and flags a key match. Depends on kms_pkg.
module kms_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  kms_pkg::cell_ctl_t     ctl,
  input  kms_pkg::entry_t        up,
  input  logic                   occupied,
  input  logic [kms_pkg::KEY_W-1:0] key,
  output kms_pkg::entry_t        cur,
  output logic                   match
);

  kms_pkg::entry_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      unique case (ctl.op)
        kms_pkg::CELL_HOLD:  slot <= slot;
        kms_pkg::CELL_LOAD:  slot <= ctl.data;
        kms_pkg::CELL_SHIFT: slot <= up;
        kms_pkg::CELL_CLEAR: slot <= '0;
        default:             slot <= slot;
      endcase
    end
  end

  assign cur   = slot;
  assign match = occupied && (key == kms_pkg::KEY_W'(slot.key));

endmodule
